### rtl/biou_pkg.sv
package biou_pkg;

  localparam int FRAC_BITS = 4;
  localparam int IOU_BITS  = 16;

  // fixed field widths of the request
  localparam int EDGE_W = 16;
  localparam int DIM_W  = 16;

  // extent plus one pixel, also bounds a positive overlap width or height
  localparam int EXT_W  = DIM_W + 1;
  // signed room for edge plus extent and for end minus start
  localparam int POS_W  = EDGE_W + 3;
  localparam int AREA_W = 2 * EXT_W - 1;
  localparam int UNI_W  = AREA_W + 1;
  localparam int REM_W  = UNI_W + 1;
  localparam int IOU_W  = IOU_BITS + 1;

  localparam int DIV_STAGES = IOU_W;

  typedef struct packed {
    logic signed [EDGE_W-1:0] a_left;
    logic signed [EDGE_W-1:0] a_top;
    logic [DIM_W-1:0]         a_width;
    logic [DIM_W-1:0]         a_height;
    logic signed [EDGE_W-1:0] b_left;
    logic signed [EDGE_W-1:0] b_top;
    logic [DIM_W-1:0]         b_width;
    logic [DIM_W-1:0]         b_height;
  } box_req_t;

  typedef struct packed {
    logic [IOU_W-1:0] iou;
    logic             overlaps;
  } iou_rsp_t;

  // hand-off from the area stages to the divider
  typedef struct packed {
    logic [AREA_W-1:0] inter;
    logic [UNI_W-1:0]  uni;
    logic              overlaps;
  } div_req_t;

endpackage

### rtl/biou_front.sv
module biou_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  biou_pkg::box_req_t req_i,
  output logic               valid_o,
  output biou_pkg::div_req_t div_o
);
  import biou_pkg::*;

  localparam logic signed [POS_W-1:0] PIX_POS = POS_W'(1 << FRAC_BITS);
  localparam logic [EXT_W-1:0]        PIX_EXT = EXT_W'(1 << FRAC_BITS);

  logic signed [POS_W-1:0] a_l, a_t, b_l, b_t, a_r, a_b, b_r, b_b;
  logic signed [POS_W-1:0] min_r, max_l, min_b, max_t, ow, oh;
  logic                    ov_d;

  // stage 1: overlap extents and box extents
  logic                v1_q;
  logic                ov1_q;
  logic [EXT_W-1:0]    ow_q, oh_q, aw_q, ah_q, bw_q, bh_q;
  // stage 2: products
  logic                v2_q;
  logic                ov2_q;
  logic [AREA_W-1:0]   inter_q, area_a_q, area_b_q;
  // stage 3: union
  logic                v3_q;
  div_req_t            div_q;

  logic [2*EXT_W-1:0]  prod_i, prod_a, prod_b;
  logic [UNI_W-1:0]    uni_d;

  always_comb begin
    a_l = {{(POS_W-EDGE_W){req_i.a_left[EDGE_W-1]}}, req_i.a_left};
    a_t = {{(POS_W-EDGE_W){req_i.a_top[EDGE_W-1]}}, req_i.a_top};
    b_l = {{(POS_W-EDGE_W){req_i.b_left[EDGE_W-1]}}, req_i.b_left};
    b_t = {{(POS_W-EDGE_W){req_i.b_top[EDGE_W-1]}}, req_i.b_top};
    a_r = a_l + $signed({{(POS_W-DIM_W){1'b0}}, req_i.a_width});
    a_b = a_t + $signed({{(POS_W-DIM_W){1'b0}}, req_i.a_height});
    b_r = b_l + $signed({{(POS_W-DIM_W){1'b0}}, req_i.b_width});
    b_b = b_t + $signed({{(POS_W-DIM_W){1'b0}}, req_i.b_height});
    min_r = (a_r < b_r) ? a_r : b_r;
    max_l = (a_l > b_l) ? a_l : b_l;
    min_b = (a_b < b_b) ? a_b : b_b;
    max_t = (a_t > b_t) ? a_t : b_t;
    ow = min_r - max_l + PIX_POS;
    oh = min_b - max_t + PIX_POS;
    ov_d = !ow[POS_W-1] && (ow != '0) && !oh[POS_W-1] && (oh != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // a positive overlap never exceeds either extent, so it fits EXT_W
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ov1_q <= ov_d;
      ow_q  <= ow[EXT_W-1:0];
      oh_q  <= oh[EXT_W-1:0];
      aw_q  <= {1'b0, req_i.a_width} + PIX_EXT;
      ah_q  <= {1'b0, req_i.a_height} + PIX_EXT;
      bw_q  <= {1'b0, req_i.b_width} + PIX_EXT;
      bh_q  <= {1'b0, req_i.b_height} + PIX_EXT;
    end
  end

  assign prod_i = ow_q * oh_q;
  assign prod_a = aw_q * ah_q;
  assign prod_b = bw_q * bh_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ov2_q    <= ov1_q;
      inter_q  <= ov1_q ? prod_i[AREA_W-1:0] : '0;
      area_a_q <= prod_a[AREA_W-1:0];
      area_b_q <= prod_b[AREA_W-1:0];
    end
  end

  assign uni_d = {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q.inter    <= inter_q;
      div_q.uni      <= uni_d;
      div_q.overlaps <= ov2_q;
    end
  end

  assign valid_o = v3_q;
  assign div_o   = div_q;

endmodule

### rtl/biou_div.sv
module biou_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  biou_pkg::div_req_t div_i,
  output logic               valid_o,
  output biou_pkg::iou_rsp_t rsp_o
);
  import biou_pkg::*;

  localparam logic [IOU_W-1:0] IOU_ONE = IOU_W'(1) << IOU_BITS;

  logic             vld_q [DIV_STAGES];
  logic             ov_q  [DIV_STAGES];
  logic [UNI_W-1:0] uni_q [DIV_STAGES];
  logic [UNI_W-1:0] rem_q [DIV_STAGES];
  logic [IOU_W-1:0] quo_q [DIV_STAGES];

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic             vld_in, ov_in, take;
    logic [UNI_W-1:0] uni_in;
    logic [REM_W-1:0] r_in, r_sub;
    logic [IOU_W-1:0] quo_in;

    if (k == 0) begin : g_first
      // first bit: inter >= union only for a full match
      assign vld_in = valid_i;
      assign ov_in  = div_i.overlaps;
      assign uni_in = div_i.uni;
      assign r_in   = REM_W'(div_i.inter);
      assign quo_in = '0;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign ov_in  = ov_q[k-1];
      assign uni_in = uni_q[k-1];
      assign r_in   = {rem_q[k-1], 1'b0};
      assign quo_in = quo_q[k-1];
    end

    assign r_sub = r_in - {1'b0, uni_in};
    assign take  = (r_in >= {1'b0, uni_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ov_q[k]  <= ov_in;
        uni_q[k] <= uni_in;
        rem_q[k] <= take ? r_sub[UNI_W-1:0] : r_in[UNI_W-1:0];
        quo_q[k] <= {quo_in[IOU_W-2:0], take};
      end
    end
  end

  assign valid_o      = vld_q[DIV_STAGES-1];
  assign rsp_o.iou    = quo_q[DIV_STAGES-1];
  assign rsp_o.overlaps = ov_q[DIV_STAGES-1];

  a_iou_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rsp_o.iou <= IOU_ONE)
    else $error("iou above one");

  a_no_overlap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !rsp_o.overlaps) |-> rsp_o.iou == '0)
    else $error("nonzero iou without overlap");

  a_rem_below_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rem_q[DIV_STAGES-1] < uni_q[DIV_STAGES-1])
    else $error("divider remainder not below union");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> (vld_q[0] == $past(vld_q[0])) && (quo_q[0] == $past(quo_q[0])))
    else $error("divider stage moved while stalled");

endmodule

### rtl/box_iou_unit.sv
// channel   | valid       | ready       | payload
// ----------+-------------+-------------+---------------------------------
// request   | in_valid_i  | in_ready_o  | in_req_i  (two boxes, Q12.4)
// result    | out_valid_o | out_ready_i | out_rsp_o (iou Q1.16, overlaps)
//
// one request per cycle sustained while out_ready_i does not stall: 3 geometry/area stages
// and 17 divider stages, one quotient bit per stage, the last one the output register.
// reset clears only the stage valid bits; data registers are not reset.
// a stall at the output freezes the whole pipeline through one shared enable,
// so in_ready_o is low exactly while a result waits and out_ready_i is low.
module box_iou_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  biou_pkg::box_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output biou_pkg::iou_rsp_t out_rsp_o
);
  import biou_pkg::*;

  logic     en;
  logic     front_valid;
  div_req_t front_div;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  biou_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (front_valid),
    .div_o   (front_div)
  );

  biou_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .div_i   (front_div),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o)
  );

endmodule

### test/box_iou_unit_test.sv
`timescale 1ns / 100ps

module box_iou_unit_test;
  import biou_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 40;
  localparam longint PIXEL   = longint'(1) << FRAC_BITS;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  box_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  iou_rsp_t out_rsp_o;

  iou_rsp_t iou_expect_q[$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  int       burst_left     = 0;
  int       stall_cycle    = 0;

  box_iou_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // inclusive-pixel iou of the two boxes, exact integer arithmetic
  function automatic iou_rsp_t predict_iou(input box_req_t r);
    longint al, at, aw, ah, bl, bt, bw, bh, ow, oh;
    longint unsigned inter, area_a, area_b, uni, quot;
    iou_rsp_t rsp;
    al = $signed(r.a_left);
    at = $signed(r.a_top);
    aw = r.a_width;
    ah = r.a_height;
    bl = $signed(r.b_left);
    bt = $signed(r.b_top);
    bw = r.b_width;
    bh = r.b_height;
    ow = ((al + aw < bl + bw) ? al + aw : bl + bw) - ((al > bl) ? al : bl) + PIXEL;
    oh = ((at + ah < bt + bh) ? at + ah : bt + bh) - ((at > bt) ? at : bt) + PIXEL;
    rsp = '0;
    if (ow > 0 && oh > 0) begin
      inter  = ow * oh;
      area_a = (aw + PIXEL) * (ah + PIXEL);
      area_b = (bw + PIXEL) * (bh + PIXEL);
      uni    = area_a + area_b - inter;
      quot   = (uni != 0) ? (inter << IOU_BITS) / uni : 0;
      rsp.iou      = quot[IOU_W-1:0];
      rsp.overlaps = 1'b1;
    end
    return rsp;
  endfunction

  function automatic box_req_t make_pair(input int al, at, aw, ah, bl, bt, bw, bh);
    box_req_t r;
    r.a_left   = 16'(al);
    r.a_top    = 16'(at);
    r.a_width  = 16'(aw);
    r.a_height = 16'(ah);
    r.b_left   = 16'(bl);
    r.b_top    = 16'(bt);
    r.b_width  = 16'(bw);
    r.b_height = 16'(bh);
    return r;
  endfunction

  // mostly a few dozen pixels, now and then the extremes or anything
  function automatic int rand_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      2, 3:    return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, 16 * 64));
    endcase
  endfunction

  function automatic int rand_edge();
    if ($urandom_range(0, 4) == 0)
      return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 16 * 200)) - 16 * 100;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_request(input box_req_t req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    iou_expect_q.push_back(predict_iou(req));
  endtask

  task automatic test_directed();
    // identical boxes, zero size and largest size
    send_request(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_pair(-32768, -32768, 65535, 65535, -32768, -32768, 65535, 65535));
    send_request(make_pair(32767, 32767, 65535, 65535, 32767, 32767, 65535, 65535));
    send_request(make_pair(160, -96, 320, 48, 160, -96, 320, 48));
    // overlap width one unit, then exactly zero, then overlap height zero
    send_request(make_pair(0, 0, 160, 160, 175, 0, 160, 160));
    send_request(make_pair(0, 0, 160, 160, 176, 0, 160, 160));
    send_request(make_pair(0, 0, 160, 160, 0, 176, 160, 160));
    send_request(make_pair(0, 0, 160, 160, 0, -176, 160, 160));
    // far apart at the edge extremes
    send_request(make_pair(-32768, -32768, 0, 0, 32767, 32767, 0, 0));
    // one box inside the other
    send_request(make_pair(-32768, -32768, 65535, 65535, 100, 100, 0, 0));
    send_request(make_pair(50, 50, 0, 0, 0, 0, 65535, 65535));
    // half overlap
    send_request(make_pair(0, 0, 160, 160, 80, 80, 160, 160));
    // edge plus extent far past 16 bits
    send_request(make_pair(32767, 32767, 65535, 65535, -32768, -32768, 65535, 65535));
    send_request(make_pair(-32768, -32768, 65535, 65535, 32767, 32767, 0, 0));
    send_request(make_pair(32767, -32768, 0, 65535, 32767, 32767, 65535, 0));
    // overlap in x only, and in y only
    send_request(make_pair(0, 0, 320, 32, 16, 4000, 320, 32));
    send_request(make_pair(0, 0, 32, 320, 4000, 16, 32, 320));
    // alternating bit patterns
    send_request(make_pair('h5555, 'haaaa, 'h5555, 'haaaa, 'haaaa, 'h5555, 'haaaa, 'h5555));
  endtask

  // b placed so that it overlaps a in both directions
  task automatic test_overlapping_pairs(input int count);
    int al, at, aw, ah, bl, bt, bw, bh;
    for (int i = 0; i < count; i++) begin
      al = rand_edge();
      at = rand_edge();
      aw = rand_dim();
      ah = rand_dim();
      if ($urandom_range(0, 7) == 0) begin
        bl = al + int'($urandom_range(0, 4)) - 2;
        bt = at + int'($urandom_range(0, 4)) - 2;
        bw = aw;
        bh = ah;
      end else begin
        bw = rand_dim();
        bh = rand_dim();
        bl = al - bw - 16 + int'($urandom_range(1, aw + bw + 31));
        bt = at - bh - 16 + int'($urandom_range(1, ah + bh + 31));
      end
      send_request(make_pair(al, at, aw, ah, bl, bt, bw, bh));
    end
  endtask

  // b right at the border of a, one side or the other
  task automatic test_touching_pairs(input int count);
    int al, at, aw, ah, bl, bt, bw, bh, k;
    for (int i = 0; i < count; i++) begin
      al = rand_edge();
      at = rand_edge();
      aw = int'($urandom_range(0, 16 * 40));
      ah = int'($urandom_range(0, 16 * 40));
      bw = int'($urandom_range(0, 16 * 40));
      bh = int'($urandom_range(0, 16 * 40));
      k  = int'($urandom_range(0, 4)) - 2;
      bl = al + int'($urandom_range(0, aw));
      bt = at + int'($urandom_range(0, ah));
      case ($urandom_range(0, 3))
        0: bl = al + aw + 16 + k;
        1: bl = al - bw - 16 + k;
        2: bt = at + ah + 16 + k;
        default: bt = at - bh - 16 + k;
      endcase
      send_request(make_pair(al, at, aw, ah, bl, bt, bw, bh));
    end
  endtask

  task automatic test_random_noise(input int count);
    box_req_t r;
    for (int i = 0; i < count; i++) begin
      r = {$urandom, $urandom, $urandom, $urandom};
      send_request(r);
    end
  endtask

  // a's edges near the ends of the range, all extents but b's height near the largest
  task automatic test_wide_extents(input int count);
    int al, at, bl, bt;
    for (int i = 0; i < count; i++) begin
      al = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 255))
                                : -32768 + int'($urandom_range(0, 255));
      at = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 255))
                                : -32768 + int'($urandom_range(0, 255));
      bl = $urandom_range(0, 1) ? al : rand_edge();
      bt = $urandom_range(0, 1) ? at : rand_edge();
      send_request(make_pair(al, at, 65535 - int'($urandom_range(0, 4095)),
                             65535 - int'($urandom_range(0, 4095)), bl, bt,
                             65535 - int'($urandom_range(0, 4095)),
                             int'($urandom_range(0, 65535))));
    end
  endtask

  // receiver stall pattern, cycling through four modes
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[9:8])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready_i <= (stall_cycle[4:0] < 5'd24);
      default: out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin : check_results
    iou_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (iou_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, iou %0d", out_rsp_o.iou));
      end else begin
        want = iou_expect_q.pop_front();
        if (out_rsp_o.iou !== want.iou)
          report_mismatch($sformatf("iou got %0d want %0d", out_rsp_o.iou, want.iou));
        if (out_rsp_o.overlaps !== want.overlaps)
          report_mismatch($sformatf("overlaps got %b want %b", out_rsp_o.overlaps,
                                    want.overlaps));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overlapping_pairs(650);
    test_touching_pairs(150);
    test_random_noise(300);
    test_wide_extents(150);
    in_valid_i <= 1'b0;
    while (iou_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
